// ----- design/mvpd_pkg.sv -----
// Package for the magnetometer vehicle presence detector.
// Holds the phase encoding, register map codes and field widths.
// No dependencies.
package mvpd_pkg;

  // Phase of the detector, as reported on phase_o
  typedef enum logic [2:0] {
    MODE_CALIB  = 3'd0,
    MODE_FREE   = 3'd1,
    MODE_ARRIVE = 3'd2,
    MODE_TAKEN  = 3'd3,
    MODE_LEAVE  = 3'd4
  } mode_e;

  // Register map: word index on the APB port
  typedef enum logic {
    REG_THRESHOLD = 1'b0,
    REG_CONFIRM   = 1'b1
  } reg_idx_e;

  localparam int unsigned CALIB_SAMPLES_DEF = 300;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned THRESH_W   = 10;
  localparam int unsigned CONFIRM_W  = 12;
  localparam int unsigned BASE_W     = 24;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  localparam int unsigned PCT_SCALE  = 100;

  localparam logic [THRESH_W-1:0]  THRESH_RST  = THRESH_W'(10);
  localparam logic [CONFIRM_W-1:0] CONFIRM_RST = CONFIRM_W'(140);

endpackage

// ----- design/magnetometer_vehicle_presence_detector_unit.sv -----
// Magnetometer vehicle presence detector, top level.
// Uses mvpd_pkg for phase codes, register map and widths.
// Each transaction passes through the input register, then the result register.
// One transaction per cycle when unstalled; the input register refills while a result waits.
// The per-sample path is two constant multiplies and a 10x24 multiply feeding the compares.
// Reset (rst_ni low, async): calibration restarts, spot free, LEDs off, registers at defaults.
module magnetometer_vehicle_presence_detector_unit #(
  parameter int unsigned CalibSamples = mvpd_pkg::CALIB_SAMPLES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [mvpd_pkg::SAMPLE_W-1:0] sample_x_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 spot_free_o,
  output logic                                 state_changed_o,
  output logic        [mvpd_pkg::PHASE_W-1:0]  phase_o,
  output logic                                 green_led_o,
  output logic                                 red_led_o,
  // APB configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [mvpd_pkg::PADDR_W-1:0]  paddr,
  input  logic        [mvpd_pkg::PDATA_W-1:0]  pwdata,
  output logic        [mvpd_pkg::PDATA_W-1:0]  prdata,
  output logic                                 pready
);

  // ---------------------------------------------------------------------------
  // Derived sizes
  // ---------------------------------------------------------------------------
  localparam int unsigned CntW   = $clog2(CalibSamples + 1);
  // sum of CalibSamples signed 16-bit samples, plus headroom
  localparam int unsigned SumW   = mvpd_pkg::SAMPLE_W + CntW;
  // |x| * CalibSamples * 100, compared against 100 * S and T * S
  localparam int unsigned KScale = CalibSamples * mvpd_pkg::PCT_SCALE;
  localparam int unsigned KW     = $clog2(KScale + 1);
  localparam int unsigned LhsW   = mvpd_pkg::SAMPLE_W + KW + 1;
  localparam int unsigned RhsW   = mvpd_pkg::THRESH_W + mvpd_pkg::BASE_W;
  localparam int unsigned CmpW   = (LhsW > RhsW) ? LhsW : RhsW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [mvpd_pkg::THRESH_W-1:0]  thresh_q;
  logic [mvpd_pkg::CONFIRM_W-1:0] confirm_q;
  logic                           cfg_wr;
  mvpd_pkg::reg_idx_e             cfg_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign cfg_idx = mvpd_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= mvpd_pkg::THRESH_RST;
      confirm_q <= mvpd_pkg::CONFIRM_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mvpd_pkg::REG_THRESHOLD: thresh_q  <= pwdata[mvpd_pkg::THRESH_W-1:0];
        mvpd_pkg::REG_CONFIRM:   confirm_q <= pwdata[mvpd_pkg::CONFIRM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mvpd_pkg::REG_THRESHOLD: prdata = mvpd_pkg::PDATA_W'(thresh_q);
      mvpd_pkg::REG_CONFIRM:   prdata = mvpd_pkg::PDATA_W'(confirm_q);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register -> result register
  // The result register drains when the consumer takes it, so the input
  // register can move forward in the same cycle.
  // ---------------------------------------------------------------------------
  logic                                 in_vld_q, in_vld_d;
  logic signed [mvpd_pkg::SAMPLE_W-1:0] sample_q;
  logic                                 out_vld_q, out_vld_d;
  logic                                 res_free;  // result register can be loaded
  logic                                 proc;      // item in input reg is processed now
  logic                                 in_acc;

  assign res_free   = !out_vld_q || !out_stall_i;
  assign proc       = in_vld_q && res_free;
  assign in_stall_o = in_vld_q && !res_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (proc) begin
      out_vld_d = 1'b1;
    end else if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sample_q <= sample_x_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Deviation test, exact:  |(|x|*N - S)| * 100  vs  T * S
  // Rewritten as | |x|*(N*100) - S*100 | so both products run in parallel.
  // ---------------------------------------------------------------------------
  logic [mvpd_pkg::BASE_W-1:0]   base_q;
  logic [mvpd_pkg::SAMPLE_W-1:0] ax;
  logic [CmpW-1:0]               lhs_a, lhs_b, lhs, rhs;
  logic                          dev, below;

  assign ax    = sample_q[mvpd_pkg::SAMPLE_W-1] ? (~sample_q + 1'b1) : sample_q;
  assign lhs_a = CmpW'(ax) * CmpW'(KScale);
  assign lhs_b = CmpW'(base_q) * CmpW'(mvpd_pkg::PCT_SCALE);
  assign lhs   = (lhs_a >= lhs_b) ? (lhs_a - lhs_b) : (lhs_b - lhs_a);
  assign rhs   = CmpW'(thresh_q) * CmpW'(base_q);

  // zero baseline: any nonzero sample deviates, nothing counts as below
  assign dev   = (base_q == '0) ? (ax != '0) : (lhs > rhs);
  assign below = (base_q != '0) && (lhs < rhs);

  // ---------------------------------------------------------------------------
  // Detector state
  // ---------------------------------------------------------------------------
  mvpd_pkg::mode_e                mode_q, mode_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic signed [SumW-1:0]         sum_q, sum_d;
  logic [mvpd_pkg::BASE_W-1:0]    base_d;
  logic [mvpd_pkg::CONFIRM_W-1:0] win_q, win_d;
  logic                           blink_q, blink_d;
  logic                           free_q, free_d;
  logic                           green_q, green_d;
  logic                           red_q, red_d;
  logic                           chg_q, chg_d;

  logic [mvpd_pkg::CONFIRM_W-1:0] win_inc;
  logic [mvpd_pkg::CONFIRM_W-1:0] win_len;
  logic                           win_done;
  logic signed [SumW-1:0]         sum_nx;
  logic [CntW-1:0]                cnt_nx;
  logic [SumW-1:0]                sum_mag;

  assign win_inc  = win_q + 1'b1;
  assign win_len  = (confirm_q == '0) ? mvpd_pkg::CONFIRM_W'(1) : confirm_q;
  assign win_done = win_inc >= win_len;

  assign sum_nx  = sum_q + SumW'(sample_q);
  assign cnt_nx  = cnt_q + 1'b1;
  assign sum_mag = sum_nx[SumW-1] ? SumW'(-sum_nx) : SumW'(sum_nx);

  always_comb begin
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    base_d  = base_q;
    win_d   = win_q;
    blink_d = blink_q;
    free_d  = free_q;
    green_d = green_q;
    red_d   = red_q;
    chg_d   = chg_q;
    if (proc) begin
      chg_d = 1'b0;
      case (mode_q)
        mvpd_pkg::MODE_FREE: begin
          if (dev) begin
            mode_d  = mvpd_pkg::MODE_ARRIVE;
            win_d   = '0;
            blink_d = 1'b0;
          end else begin
            green_d = 1'b1;
          end
        end
        mvpd_pkg::MODE_TAKEN: begin
          if (!dev) begin
            mode_d  = mvpd_pkg::MODE_LEAVE;
            win_d   = '0;
            blink_d = 1'b0;
          end
        end
        mvpd_pkg::MODE_ARRIVE: begin
          if (below) begin
            // aborted arrival
            green_d = 1'b1;
            mode_d  = mvpd_pkg::MODE_FREE;
          end else begin
            green_d = !blink_q;
            blink_d = !blink_q;
            win_d   = win_inc;
            if (win_done) begin
              free_d  = 1'b0;
              red_d   = 1'b1;
              green_d = 1'b0;
              chg_d   = 1'b1;
              mode_d  = mvpd_pkg::MODE_TAKEN;
            end
          end
        end
        mvpd_pkg::MODE_LEAVE: begin
          if (!below) begin
            // aborted departure
            red_d  = 1'b1;
            mode_d = mvpd_pkg::MODE_TAKEN;
          end else begin
            red_d   = !blink_q;
            blink_d = !blink_q;
            win_d   = win_inc;
            if (win_done) begin
              free_d  = 1'b1;
              green_d = 1'b1;
              red_d   = 1'b0;
              chg_d   = 1'b1;
              mode_d  = mvpd_pkg::MODE_FREE;
            end
          end
        end
        default: begin
          // calibration: accumulate, baseline = |sum|
          sum_d = sum_nx;
          cnt_d = cnt_nx;
          if (cnt_nx >= CntW'(CalibSamples)) begin
            base_d = mvpd_pkg::BASE_W'(sum_mag);
            mode_d = mvpd_pkg::MODE_FREE;
          end else begin
            mode_d = mvpd_pkg::MODE_CALIB;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= mvpd_pkg::MODE_CALIB;
      cnt_q   <= '0;
      sum_q   <= '0;
      base_q  <= '0;
      win_q   <= '0;
      blink_q <= 1'b0;
      free_q  <= 1'b1;
      green_q <= 1'b0;
      red_q   <= 1'b0;
      chg_q   <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      base_q  <= base_d;
      win_q   <= win_d;
      blink_q <= blink_d;
      free_q  <= free_d;
      green_q <= green_d;
      red_q   <= red_d;
      chg_q   <= chg_d;
    end
  end

  // state registers only move with a processed transaction, so they double
  // as the result register
  assign out_valid_o     = out_vld_q;
  assign spot_free_o     = free_q;
  assign state_changed_o = chg_q;
  assign phase_o         = mode_q;
  assign green_led_o     = green_q;
  assign red_led_o       = red_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a commit always lands in the matching settled phase
  a_commit_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && state_changed_o |->
      (phase_o == mvpd_pkg::MODE_FREE && spot_free_o) ||
      (phase_o == mvpd_pkg::MODE_TAKEN && !spot_free_o))
    else $error("commit reported with inconsistent phase/occupancy");

  // confirmation windows only run from the opposite committed state
  a_confirm_occ : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == mvpd_pkg::MODE_ARRIVE |-> free_q) and
    (mode_q == mvpd_pkg::MODE_LEAVE |-> !free_q))
    else $error("confirmation phase does not match occupancy");

  // input stalls only when a held transaction cannot move on
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q && out_stall_i)
    else $error("input stalled without backpressure");

  // calibration is never re-entered
  a_no_recal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != mvpd_pkg::MODE_CALIB |=> mode_q != mvpd_pkg::MODE_CALIB)
    else $error("detector fell back into calibration");

endmodule

// ----- test/tb_magnetometer_vehicle_presence_detector_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for magnetometer_vehicle_presence_detector_unit.
// A cycle-free predictor tracks calibration, confirmation windows and LEDs per sample.
// Depends on mvpd_pkg and the unit's RTL; reads no files.
module tb_magnetometer_vehicle_presence_detector_unit;

  // Generous watchdog: a run is roughly 650 transactions, plus the HOLD_CYCLES hold-off
  // and the register accesses
  localparam int unsigned CYCLE_LIMIT = 200_000;
  // Calibration is steered so the baseline sum is exactly BASE_MAG * CALIB_SAMPLES_DEF;
  // that puts "exactly on the threshold" samples at integer magnitudes.
  localparam int          BASE_MAG    = 1000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 28;

  // Hand-picked walk through every phase with threshold 10 and a 3-sample window
  localparam int PROBES[16] = '{1000, 1100, -1101, 1100, 32767, -32768, 0, 900,
                                950, -1100, 1050, 1000, -999, 1001, 5000, 1000};
  // Random phases: threshold / window pairs, extremes included (window 0 acts as 1)
  localparam int unsigned PHASE_THR[8] = '{25, 0, 1000, 100, 50, 7, 400, 3};
  localparam int unsigned PHASE_LEN[8] = '{1, 2, 5, 0, 8, 12, 3, 6};

  typedef struct packed {
    logic                         spot_free;
    logic                         state_changed;
    logic [mvpd_pkg::PHASE_W-1:0] phase;
    logic                         green;
    logic                         red;
  } presence_t;

  // DUT connections, all inputs known from time zero
  logic                                 clk_i       = 1'b0;
  logic                                 rst_ni      = 1'b0;
  logic                                 in_valid_i  = 1'b0;
  logic                                 in_stall_o;
  logic signed [mvpd_pkg::SAMPLE_W-1:0] sample_x_i  = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i = 1'b0;
  logic                                 spot_free_o;
  logic                                 state_changed_o;
  logic        [mvpd_pkg::PHASE_W-1:0]  phase_o;
  logic                                 green_led_o;
  logic                                 red_led_o;
  logic                                 psel        = 1'b0;
  logic                                 penable     = 1'b0;
  logic                                 pwrite      = 1'b0;
  logic        [mvpd_pkg::PADDR_W-1:0]  paddr       = '0;
  logic        [mvpd_pkg::PDATA_W-1:0]  pwdata      = '0;
  logic        [mvpd_pkg::PDATA_W-1:0]  prdata;
  logic                                 pready;

  // Stimulus and scoreboard storage
  logic signed [mvpd_pkg::SAMPLE_W-1:0] pending_samples[$];
  presence_t                  expected_reports[$];
  bit                         offer_open   = 1'b0;  // sample popped, not yet accepted
  bit                         steady_run   = 1'b0;  // no idling in this phase
  bit                         hold_done    = 1'b0;
  int                         gap_left     = 0;
  int                         stall_left   = 0;
  int                         hold_left    = 0;
  int                         reports_seen = 0;
  int                         mismatch_count = 0;
  int unsigned                cycle_count  = 0;

  // Predictor state: register copies and detector state
  logic [mvpd_pkg::THRESH_W-1:0]   cfg_threshold;
  logic [mvpd_pkg::CONFIRM_W-1:0]  cfg_confirm;
  mvpd_pkg::mode_e                 det_mode;
  logic [8:0]                      det_ccount;
  logic signed [25:0]              det_csum;
  logic [mvpd_pkg::BASE_W-1:0]     det_base;
  logic [mvpd_pkg::CONFIRM_W-1:0]  det_window;
  logic                            det_blink;
  logic                            det_free;
  logic                            det_green;
  logic                            det_red;

  magnetometer_vehicle_presence_detector_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_x_i     (sample_x_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .spot_free_o    (spot_free_o),
    .state_changed_o(state_changed_o),
    .phase_o        (phase_o),
    .green_led_o    (green_led_o),
    .red_led_o      (red_led_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Advance the confirmation window; true once it has run its full length.
  function automatic logic window_filled();
    logic [mvpd_pkg::CONFIRM_W-1:0] span;
    span = (cfg_confirm == '0) ? mvpd_pkg::CONFIRM_W'(1) : cfg_confirm;
    det_window = det_window + 1'b1;
    return det_window >= span;
  endfunction

  // One accepted sample: update the detector copy and queue the report it causes.
  task automatic advance_detector(input logic signed [mvpd_pkg::SAMPLE_W-1:0] x);
    longint    xi, mag, base, scaled, offset, lhs, rhs, sum_abs;
    logic      deviates, below, changed;
    presence_t rpt;
    xi     = x;
    mag    = (xi < 0) ? -xi : xi;
    base   = det_base;
    scaled = mag * longint'(mvpd_pkg::CALIB_SAMPLES_DEF);
    offset = (scaled >= base) ? scaled - base : base - scaled;
    // percent test by cross-multiplication: offset/base*100 vs threshold
    lhs    = offset * longint'(mvpd_pkg::PCT_SCALE);
    rhs    = longint'(cfg_threshold) * base;
    // zero baseline: any nonzero sample deviates, nothing is ever below
    deviates = (base == 0) ? (mag != 0) : (lhs > rhs);
    below    = (base != 0) && (lhs < rhs);
    changed  = 1'b0;
    case (det_mode)
      mvpd_pkg::MODE_FREE: begin
        if (deviates) begin
          det_mode   = mvpd_pkg::MODE_ARRIVE;
          det_window = '0;
          det_blink  = 1'b0;
        end else begin
          det_green = 1'b1;
        end
      end
      mvpd_pkg::MODE_TAKEN: begin
        if (!deviates) begin
          det_mode   = mvpd_pkg::MODE_LEAVE;
          det_window = '0;
          det_blink  = 1'b0;
        end
      end
      mvpd_pkg::MODE_ARRIVE: begin
        if (below) begin
          det_green = 1'b1;
          det_mode  = mvpd_pkg::MODE_FREE;
        end else begin
          det_green = ~det_blink;
          det_blink = ~det_blink;
          if (window_filled()) begin
            det_free  = 1'b0;
            det_red   = 1'b1;
            det_green = 1'b0;
            changed   = 1'b1;
            det_mode  = mvpd_pkg::MODE_TAKEN;
          end
        end
      end
      mvpd_pkg::MODE_LEAVE: begin
        if (!below) begin
          det_red  = 1'b1;
          det_mode = mvpd_pkg::MODE_TAKEN;
        end else begin
          det_red   = ~det_blink;
          det_blink = ~det_blink;
          if (window_filled()) begin
            det_free  = 1'b1;
            det_green = 1'b1;
            det_red   = 1'b0;
            changed   = 1'b1;
            det_mode  = mvpd_pkg::MODE_FREE;
          end
        end
      end
      default: begin
        // calibrating; the sample that completes it already reports free
        det_csum   = det_csum + x;
        det_ccount = det_ccount + 1'b1;
        if (det_ccount >= mvpd_pkg::CALIB_SAMPLES_DEF) begin
          sum_abs  = det_csum;
          sum_abs  = (sum_abs < 0) ? -sum_abs : sum_abs;
          det_base = mvpd_pkg::BASE_W'(sum_abs);
          det_mode = mvpd_pkg::MODE_FREE;
        end else begin
          det_mode = mvpd_pkg::MODE_CALIB;
        end
      end
    endcase
    rpt.spot_free     = det_free;
    rpt.state_changed = changed;
    rpt.phase         = det_mode;
    rpt.green         = det_green;
    rpt.red           = det_red;
    expected_reports.push_back(rpt);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle length for either side: mostly none, some short, a few long
  function automatic int idle_length();
    int pick;
    if (steady_run) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic signed [mvpd_pkg::SAMPLE_W-1:0] apply_sign(input int mag);
    if ($urandom_range(0, 1) == 1) return mvpd_pkg::SAMPLE_W'(-mag);
    return mvpd_pkg::SAMPLE_W'(mag);
  endfunction

  // Sample that is not below threshold: mostly deviating, some exactly on it
  function automatic logic signed [mvpd_pkg::SAMPLE_W-1:0] present_sample();
    int band, pick, mag;
    band = 10 * int'(cfg_threshold);
    pick = $urandom_range(0, 99);
    if (pick < 15) mag = BASE_MAG + band;
    else if (pick < 40 && band < BASE_MAG) mag = $urandom_range(0, BASE_MAG - band - 1);
    else mag = BASE_MAG + band + 1 + $urandom_range(0, 3000);
    return apply_sign(mag);
  endfunction

  // Sample below threshold; with threshold 0 nothing is below, so send the exact baseline
  function automatic logic signed [mvpd_pkg::SAMPLE_W-1:0] absent_sample();
    int band, lo;
    band = 10 * int'(cfg_threshold);
    if (band == 0) return apply_sign(BASE_MAG);
    lo = (band >= BASE_MAG) ? 0 : BASE_MAG - band + 1;
    return apply_sign($urandom_range(lo, BASE_MAG + band - 1));
  endfunction

  // Alternating runs of vehicle present / absent. Long runs outlast the window and
  // commit, short ones abort it. A sprinkle of full-range noise in between.
  task automatic queue_runs(input int n_items, input int window);
    int run_len;
    bit present;
    present = $urandom_range(0, 1);
    while (n_items > 0) begin
      if ($urandom_range(0, 9) < 6) run_len = window + 1 + $urandom_range(0, 2);
      else run_len = $urandom_range(1, window);
      repeat (run_len) begin
        if ($urandom_range(0, 99) < 8) begin
          pending_samples.push_back(mvpd_pkg::SAMPLE_W'($urandom));
        end else if (present) begin
          pending_samples.push_back(present_sample());
        end else begin
          pending_samples.push_back(absent_sample());
        end
        n_items--;
      end
      present = !present;
    end
  endtask

  // One APB transaction: setup cycle, access cycle, completes when pready is high
  task automatic apb_access(input mvpd_pkg::reg_idx_e idx, input bit write,
                            input logic [mvpd_pkg::PDATA_W-1:0] wdata);
    logic [mvpd_pkg::PDATA_W-1:0] want;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (write) begin
      if (idx == mvpd_pkg::REG_THRESHOLD) cfg_threshold = wdata[mvpd_pkg::THRESH_W-1:0];
      else cfg_confirm = wdata[mvpd_pkg::CONFIRM_W-1:0];
    end else begin
      want = (idx == mvpd_pkg::REG_THRESHOLD) ? mvpd_pkg::PDATA_W'(cfg_threshold)
                                               : mvpd_pkg::PDATA_W'(cfg_confirm);
      if (prdata !== want) begin
        $error("prdata reg %s: expected %0d, actual %0d", idx.name(), want, prdata);
        mismatch_count++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write both registers (junk in the unused upper bits), then read them back
  task automatic program_detector(input int unsigned thr, input int unsigned len);
    apb_access(mvpd_pkg::REG_THRESHOLD, 1'b1, ($urandom & ~32'h3FF) | thr);
    apb_access(mvpd_pkg::REG_CONFIRM, 1'b1, ($urandom & ~32'hFFF) | len);
    apb_access(mvpd_pkg::REG_THRESHOLD, 1'b0, '0);
    apb_access(mvpd_pkg::REG_CONFIRM, 1'b0, '0);
  endtask

  // Block is idle once every sample is accepted and every report has come back;
  // the task then waits out the two-stage pipe.
  task automatic wait_drained();
    while (pending_samples.size() != 0 || offer_open || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [2:0] want,
                                      input logic [2:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers pending samples, predicts each one at its accepting edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_x_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        advance_detector(sample_x_i);
        offer_open = 1'b0;
      end
      // a stalled transaction keeps its payload and valid untouched
      if (!offer_open) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          sample_x_i <= pending_samples.pop_front();
          in_valid_i <= 1'b1;
          offer_open = 1'b1;
          gap_left   = idle_length();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transaction, drives random stalls and one long
  // hold-off while samples keep coming so the unit fills and stalls its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    presence_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_reports.size() == 0) begin
          $error("result transaction with no expected report");
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("spot_free", want.spot_free, spot_free_o);
          check_field("state_changed", want.state_changed, state_changed_o);
          check_field("phase", want.phase, phase_o);
          check_field("green_led", want.green, green_led_o);
          check_field("red_led", want.red, red_led_o);
        end
        reports_seen++;
      end
      if (!hold_done && reports_seen > 330 && pending_samples.size() > 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = idle_length();
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, calibration with directed walk, random phases, long window
  // ---------------------------------------------------------------------------
  initial begin
    int calib_total;
    int s;
    cfg_threshold = mvpd_pkg::THRESH_RST;
    cfg_confirm   = mvpd_pkg::CONFIRM_RST;
    det_mode      = mvpd_pkg::MODE_CALIB;
    det_ccount    = '0;
    det_csum      = '0;
    det_base      = '0;
    det_window    = '0;
    det_blink     = 1'b0;
    det_free      = 1'b1;
    det_green     = 1'b0;
    det_red       = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    program_detector(10, 3);

    // Calibration: field extremes first, then samples near -BASE_MAG; the last one
    // trims the sum so its magnitude is exactly BASE_MAG per sample (negative sum).
    calib_total = 0;
    for (int k = 0; k < int'(mvpd_pkg::CALIB_SAMPLES_DEF) - 1; k++) begin
      if (k == 0) s = -32768;
      else if (k == 1) s = 32767;
      else if (k == 2) s = 0;
      else s = -BASE_MAG + int'($urandom_range(0, 600)) - 300;
      calib_total += s;
      pending_samples.push_back(mvpd_pkg::SAMPLE_W'(s));
    end
    pending_samples.push_back(mvpd_pkg::SAMPLE_W'(
        -BASE_MAG * int'(mvpd_pkg::CALIB_SAMPLES_DEF) - calib_total));
    // Directed walk: on-threshold samples, arrival, extremes, aborts, leaving
    foreach (PROBES[i]) pending_samples.push_back(mvpd_pkg::SAMPLE_W'(PROBES[i]));
    wait_drained();

    foreach (PHASE_THR[i]) begin
      steady_run = (i == 2);
      program_detector(PHASE_THR[i], PHASE_LEN[i]);
      queue_runs(PHASE_ITEMS, (PHASE_LEN[i] == 0) ? 1 : PHASE_LEN[i]);
      wait_drained();
    end
    steady_run = 1'b0;

    // Register extremes read back, then park the spot as free with a one-sample
    // window and commit an arrival through a long window.
    program_detector(1000, 4095);
    program_detector(1000, 1);
    repeat (3) pending_samples.push_back(absent_sample());
    wait_drained();
    program_detector(1000, 48);
    repeat (52) pending_samples.push_back(present_sample());
    queue_runs(20, 6);
    wait_drained();

    program_detector($urandom_range(0, 1000), $urandom_range(1, 16));
    queue_runs(PHASE_ITEMS, int'(cfg_confirm));
    wait_drained();

    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
